>>> rtl/core/hhrgb_pkg.sv
// Shared constants and stage payload types for the HSL/HWB to RGB converter.
`default_nettype none

package hhrgb_pkg;

    localparam int FRAC_BITS     = 12;
    localparam int HUE_FRAC_BITS = 8;

    localparam int FW    = FRAC_BITS + 1;
    localparam int HW    = 11;
    localparam int KW    = FW + 1;
    localparam int FACW  = HUE_FRAC_BITS + 1;
    localparam int SUMW  = FW + 1;
    localparam int PRODW = SUMW + 1 + KW;

    localparam logic [FW-1:0]   ONE        = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FW-1:0]   HALF       = ONE >> 1;
    localparam logic [FACW-1:0] HUE_ONE    = {1'b1, {HUE_FRAC_BITS{1'b0}}};
    localparam logic [HW-1:0]   HUE_PERIOD = HW'(6 * (1 << HUE_FRAC_BITS));

    localparam logic CMD_HSL = 1'b0;
    localparam logic CMD_HWB = 1'b1;

    typedef struct packed {
        logic [2:0]           sext;
        logic [FACW-1:0]      fac;
        logic [FW-1:0]        oma;
        logic [FW-1:0]        s;
        logic [FW-1:0]        l;
        logic [FW-1:0]        p;
        logic signed [KW-1:0] k;
    } t_front;

    typedef struct packed {
        logic [2:0]           sext;
        logic [FW-1:0]        c;
        logic [FW-1:0]        x;
        logic [FW-1:0]        m;
        logic [FW-1:0]        p;
        logic signed [KW-1:0] k;
    } t_chroma;

endpackage

`default_nettype wire

>>> rtl/core/hhrgb_front.sv
// Input stage: clamps fractions, wraps the hue and prepares chroma and hue factors.
`default_nettype none

module hhrgb_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_command,
    input  logic [hhrgb_pkg::HW-1:0]    i_hue,
    input  logic [hhrgb_pkg::FW-1:0]    i_sat_or_white,
    input  logic [hhrgb_pkg::FW-1:0]    i_light_or_black,
    output logic                        o_valid,
    input  logic                        i_stall,
    output hhrgb_pkg::t_front           o_data
);
    import hhrgb_pkg::*;

    logic [FW-1:0]        p;
    logic [FW-1:0]        q;
    logic [FW-1:0]        s_eff;
    logic [FW-1:0]        l_eff;
    logic [FW:0]          two_l;
    logic [FW-1:0]        a;
    logic [HW-1:0]        h;
    logic [FACW-1:0]      hh;
    logic [FACW-1:0]      fac;
    logic signed [KW-1:0] k;
    logic [FW-1:0]        p_add;
    logic                 en;
    t_front               n_data;
    t_front               r_data;
    logic                 r_valid;

    always_comb begin
        p     = (i_sat_or_white > ONE) ? ONE : i_sat_or_white;
        q     = (i_light_or_black > ONE) ? ONE : i_light_or_black;
        s_eff = (i_command == CMD_HWB) ? ONE : p;
        l_eff = (i_command == CMD_HWB) ? HALF : q;
        two_l = {l_eff, 1'b0};
        if (two_l >= {1'b0, ONE}) begin
            a = FW'(two_l - {1'b0, ONE});
        end else begin
            a = FW'({1'b0, ONE} - two_l);
        end
        h   = (i_hue >= HUE_PERIOD) ? HW'(i_hue - HUE_PERIOD) : i_hue;
        hh  = h[HUE_FRAC_BITS:0];
        if (hh[HUE_FRAC_BITS]) begin
            fac = HUE_ONE - {1'b0, hh[HUE_FRAC_BITS-1:0]};
        end else begin
            fac = hh;
        end
        if (i_command == CMD_HWB) begin
            k     = $signed({1'b0, ONE}) - $signed({1'b0, p}) - $signed({1'b0, q});
            p_add = p;
        end else begin
            k     = $signed({1'b0, ONE});
            p_add = '0;
        end
        n_data.sext = 3'(h >> HUE_FRAC_BITS);
        n_data.fac  = fac;
        n_data.oma  = ONE - a;
        n_data.s    = s_eff;
        n_data.l    = l_eff;
        n_data.p    = p_add;
        n_data.k    = k;
    end

    assign en      = !r_valid || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/hhrgb_chroma.sv
// Two multiply stages: chroma from lightness and saturation, then the second component.
`default_nettype none

module hhrgb_chroma (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  hhrgb_pkg::t_front   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output hhrgb_pkg::t_chroma  o_data
);
    import hhrgb_pkg::*;

    typedef struct packed {
        logic [2:0]           sext;
        logic [FACW-1:0]      fac;
        logic [FW-1:0]        c;
        logic [FW-1:0]        l;
        logic [FW-1:0]        p;
        logic signed [KW-1:0] k;
    } t_mid;

    logic [2*FW-1:0]     prod_c;
    logic [FW+FACW-1:0]  prod_x;
    logic                en2;
    logic                en3;
    t_mid                n_mid;
    t_mid                r_mid;
    t_chroma             n_out;
    t_chroma             r_out;
    logic                r_v2;
    logic                r_v3;

    always_comb begin
        prod_c     = i_data.oma * i_data.s;
        n_mid.sext = i_data.sext;
        n_mid.fac  = i_data.fac;
        n_mid.c    = prod_c[FRAC_BITS +: FW];
        n_mid.l    = i_data.l;
        n_mid.p    = i_data.p;
        n_mid.k    = i_data.k;
    end

    always_comb begin
        prod_x     = r_mid.c * r_mid.fac;
        n_out.sext = r_mid.sext;
        n_out.c    = r_mid.c;
        n_out.x    = prod_x[HUE_FRAC_BITS +: FW];
        n_out.m    = r_mid.l - (r_mid.c >> 1);
        n_out.p    = r_mid.p;
        n_out.k    = r_mid.k;
    end

    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign o_stall = !en2;
    assign o_valid = r_v3;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en2) begin
                r_v2 <= i_valid;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && i_valid) begin
            r_mid <= n_mid;
        end
        if (en3 && r_v2) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/hhrgb_mix.sv
// Channel placement by sextant, whiteness/blackness scaling and final clamping.
`default_nettype none

module hhrgb_mix (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  hhrgb_pkg::t_chroma        i_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [hhrgb_pkg::FW-1:0]  o_red,
    output logic [hhrgb_pkg::FW-1:0]  o_green,
    output logic [hhrgb_pkg::FW-1:0]  o_blue
);
    import hhrgb_pkg::*;

    logic [FW-1:0]           ch [3];
    logic [SUMW-1:0]         n_sum [3];
    logic [SUMW-1:0]         r_sum [3];
    logic signed [KW-1:0]    r_k4;
    logic [FW-1:0]           r_p4;
    logic signed [PRODW-1:0] n_prod [3];
    logic signed [PRODW-1:0] r_prod [3];
    logic [FW-1:0]           r_p5;
    logic signed [PRODW-1:0] val [3];
    logic [FW-1:0]           n_res [3];
    logic [FW-1:0]           r_res [3];
    logic                    en4;
    logic                    en5;
    logic                    en6;
    logic                    r_v4;
    logic                    r_v5;
    logic                    r_v6;

    always_comb begin
        ch[0] = '0;
        ch[1] = '0;
        ch[2] = '0;
        case (i_data.sext)
            3'd0: begin
                ch[0] = i_data.c;
                ch[1] = i_data.x;
            end
            3'd1: begin
                ch[0] = i_data.x;
                ch[1] = i_data.c;
            end
            3'd2: begin
                ch[1] = i_data.c;
                ch[2] = i_data.x;
            end
            3'd3: begin
                ch[1] = i_data.x;
                ch[2] = i_data.c;
            end
            3'd4: begin
                ch[0] = i_data.x;
                ch[2] = i_data.c;
            end
            default: begin
                ch[0] = i_data.c;
                ch[2] = i_data.x;
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = {1'b0, ch[i]} + {1'b0, i_data.m};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_prod[i] = $signed({1'b0, r_sum[i]}) * r_k4;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            val[i] = (r_prod[i] >>> FRAC_BITS) + $signed(PRODW'(r_p5));
            if (val[i] < 0) begin
                n_res[i] = '0;
            end else if (val[i] > $signed(PRODW'(ONE))) begin
                n_res[i] = ONE;
            end else begin
                n_res[i] = val[i][FW-1:0];
            end
        end
    end

    assign en6     = !r_v6 || !i_stall;
    assign en5     = !r_v5 || en6;
    assign en4     = !r_v4 || en5;
    assign o_stall = !en4;
    assign o_valid = r_v6;
    assign o_red   = r_res[0];
    assign o_green = r_res[1];
    assign o_blue  = r_res[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en4) begin
                r_v4 <= i_valid;
            end
            if (en5) begin
                r_v5 <= r_v4;
            end
            if (en6) begin
                r_v6 <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && i_valid) begin
            r_sum <= n_sum;
            r_k4  <= i_data.k;
            r_p4  <= i_data.p;
        end
        if (en5 && r_v4) begin
            r_prod <= n_prod;
            r_p5   <= r_p4;
        end
        if (en6 && r_v5) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/hsl_hwb_to_rgb_converter.sv
// Top level of the HSL/HWB to RGB color converter pipeline.
//
// One request carries a command (HSL or HWB), a hue in Q8 sextants and two
// Q12 fractions; one result carries red, green and blue as Q12 fractions.
// Both channels use valid and stall: a request moves on a rising edge where
// valid is high and stall is low. Hues of six sextants or more wrap, and
// fractions above one are taken as one.
// The pipeline has six register stages; a result is presented from the last
// of them and is taken on a rising edge where stall is low.
// A new request is taken every cycle while the receiver does not stall; the
// pipeline depth follows from the chroma multiply, the second-component
// multiply and the scaling multiply, each of which has a stage of its own.
// Every stage holds a valid bit and moves forward whenever the stage after it
// is empty or moving, so empty stages close up while the receiver stalls and
// the input keeps accepting until the pipeline is full. A stalled result
// holds its value.
// Reset clears all valid bits; the pipeline comes up empty and ready.
`default_nettype none

module hsl_hwb_to_rgb_converter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_command,
    input  logic [hhrgb_pkg::HW-1:0]  i_hue,
    input  logic [hhrgb_pkg::FW-1:0]  i_sat_or_white,
    input  logic [hhrgb_pkg::FW-1:0]  i_light_or_black,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [hhrgb_pkg::FW-1:0]  o_red,
    output logic [hhrgb_pkg::FW-1:0]  o_green,
    output logic [hhrgb_pkg::FW-1:0]  o_blue
);
    import hhrgb_pkg::*;

    t_front  front_data;
    logic    front_valid;
    logic    front_stall;
    t_chroma chroma_data;
    logic    chroma_valid;
    logic    chroma_stall;

    hhrgb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_hue            (i_hue),
        .i_sat_or_white   (i_sat_or_white),
        .i_light_or_black (i_light_or_black),
        .o_valid          (front_valid),
        .i_stall          (front_stall),
        .o_data           (front_data)
    );

    hhrgb_chroma u_chroma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_stall (front_stall),
        .i_data  (front_data),
        .o_valid (chroma_valid),
        .i_stall (chroma_stall),
        .o_data  (chroma_data)
    );

    hhrgb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chroma_valid),
        .o_stall (chroma_stall),
        .i_data  (chroma_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

`default_nettype wire
